[rtl/mrh_pkg.sv]
`default_nettype none

package mrh_pkg;

  // Width of the configuration registers and of the returned coordinates.
  localparam int CFG_W   = 9;
  localparam int COORD_W = 8;

  // Configuration register indexes.
  localparam logic CFG_IDX_WIDTH  = 1'b0;
  localparam logic CFG_IDX_HEIGHT = 1'b1;

  typedef enum logic [1:0] {
    REQ_PIXEL  = 2'd0,
    REQ_VERTEX = 2'd1,
    REQ_FRAME  = 2'd2,
    REQ_NONE   = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    ST_VERTEX    = 3'd0,
    ST_CLOSE     = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_NOFULCRUM = 3'd3,
    ST_DONE      = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_WALK = 2'd1,
    PH_DONE = 2'd2
  } phase_e;

endpackage

`default_nettype wire

[rtl/mask_row_extent_convex_hull.sv]
`default_nettype none

// Convex hull of a binary mask from its row end points. Mask pixels (one
// beat each) and frame starts are taken only while the sequencer is idle, and pixels keep
// flowing while a hull answer waits on the output. A vertex request sweeps
// the extent memory once: a read and a check for each row below the current height,
// a right-end test for each occupied row, then a final step that registers the result;
// the start request stops at the first occupied row, and a request after the walk has
// ended answers straight from the idle state without a sweep. The sweep is bounded by
// the single read port of the extent memory, its registered read and the one candidate
// test per cycle.
module mask_row_extent_convex_hull import mrh_pkg::*; #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic               cfg_idx_i,
  input  wire logic [CFG_W-1:0]   cfg_wdata_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [1:0]         req_type_i,
  input  wire logic               pixel_set_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [COORD_W-1:0]      vertex_x_o,
  output logic [COORD_W-1:0]      vertex_y_o,
  output logic [2:0]              hull_status_o
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int DW = ((CW > RW) ? CW : RW) + 1;
  localparam int PW = 2 * DW;
  localparam int SW = PW + 1;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_LEFT  = 5'b00100,
    S_RIGHT = 5'b01000,
    S_FIN   = 5'b10000
  } state_e;

  logic [CFG_W-1:0] width_q, height_q;
  logic [CW:0]      w_c;
  logic [RW:0]      h_c;

  logic [CW-1:0]    scan_col_q, col_d;
  logic [RW:0]      scan_row_q, row_d;
  logic             cur_occ_q;
  logic [CW-1:0]    cur_left_q, cur_right_q;

  state_e           state_q;
  phase_e           phase_q;
  logic             start_mode_q;
  logic [RW:0]      j_q;
  logic             found_q;
  logic signed [DW-1:0] bdx_q, bdy_q, dirx_q, diry_q;
  logic [CW-1:0]    bx_q, pivx_q;
  logic [RW-1:0]    by_q, pivy_q;

  logic             out_valid_q;
  logic [COORD_W-1:0] vx_q, vy_q;
  status_e          st_q;

  logic             accept;
  req_e             req;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CFG_W'(256);
      height_q <= CFG_W'(256);
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_IDX_WIDTH) begin
        width_q <= cfg_wdata_i;
      end else begin
        height_q <= cfg_wdata_i;
      end
    end
  end

  // Frame dimensions saturated to the supported range.
  always_comb begin
    if (width_q == '0) begin
      w_c = (CW+1)'(1);
    end else if (int'(width_q) > MAX_WIDTH) begin
      w_c = (CW+1)'(MAX_WIDTH);
    end else begin
      w_c = (CW+1)'(width_q);
    end
    if (height_q == '0) begin
      h_c = (RW+1)'(1);
    end else if (int'(height_q) > MAX_HEIGHT) begin
      h_c = (RW+1)'(MAX_HEIGHT);
    end else begin
      h_c = (RW+1)'(height_q);
    end
  end

  assign req        = req_e'(req_type_i);
  assign in_ready_o = (state_q == S_IDLE) && !(out_valid_q && (req == REQ_VERTEX));
  assign accept     = in_valid_i && in_ready_o;

  // Raster position of the incoming pixel, with wrap when the width shrank.
  logic [CW:0]   c0, c1;
  logic [RW:0]   r0;
  logic          pix_in;
  always_comb begin
    c0 = {1'b0, scan_col_q};
    r0 = scan_row_q;
    if (c0 >= w_c) begin
      c0 = '0;
      if (r0 < h_c) begin
        r0 = r0 + 1'b1;
      end
    end
    pix_in = (r0 < h_c);
    c1     = c0 + 1'b1;
    col_d  = c0[CW-1:0];
    row_d  = r0;
    if (pix_in) begin
      if (c1 >= w_c) begin
        col_d = '0;
        row_d = r0 + 1'b1;
      end else begin
        col_d = c1[CW-1:0];
      end
    end
  end

  // Pixels arrive in raster order, so a row always starts at column zero,
  // its left end is the first set column and its right end the latest one.
  // Every placed pixel rewrites the whole row word.
  logic          pix_we, row_first, pix_occ;
  logic [RW-1:0] pix_addr;
  logic [CW-1:0] pix_left, pix_right;
  assign pix_addr  = r0[RW-1:0];
  assign row_first = (c0 == '0);
  assign pix_we    = accept && (req == REQ_PIXEL) && pix_in;
  assign pix_occ   = pixel_set_i || (!row_first && cur_occ_q);
  assign pix_left  = (pixel_set_i && (row_first || !cur_occ_q)) ? c0[CW-1:0] : cur_left_q;
  assign pix_right = pixel_set_i ? c0[CW-1:0] : cur_right_q;

  logic [2*CW:0]   rd_data;
  logic            rd_occ;
  logic [CW-1:0]   rd_left, rd_right;

  mrh_ext_ram #(
    .DEPTH (MAX_HEIGHT),
    .AW    (RW),
    .DW    (2 * CW + 1)
  ) u_ext_ram (
    .clk_i   (clk_i),
    .we_i    (pix_we),
    .waddr_i (pix_addr),
    .wdata_i ({pix_occ, pix_left, pix_right}),
    .raddr_i (j_q[RW-1:0]),
    .rdata_o (rd_data)
  );

  assign rd_occ   = rd_data[2*CW];
  assign rd_left  = rd_data[2*CW-1:CW];
  assign rd_right = rd_data[CW-1:0];

  // A row word is current only once the scan of this frame has reached it.
  logic row_written, row_hit;
  assign row_written = (j_q < scan_row_q) || ((j_q == scan_row_q) && (scan_col_q != '0));
  assign row_hit     = row_written && rd_occ;

  // Candidate test against the current direction and the best so far.
  logic [CW-1:0]        cand_col;
  logic signed [DW-1:0] px, py;
  logic signed [PW-1:0] cd_l, cd_r, cb_l, cb_r;
  logic signed [SW-1:0] pd, bd;
  logic                 take;
  always_comb begin
    cand_col = (state_q == S_LEFT) ? rd_left : rd_right;
    px   = $signed(DW'(cand_col) - DW'(pivx_q));
    py   = $signed(DW'(j_q[RW-1:0]) - DW'(pivy_q));
    cd_l = px * diry_q;
    cd_r = py * dirx_q;
    cb_l = px * bdy_q;
    cb_r = py * bdx_q;
    pd   = px * px + py * py;
    bd   = bdx_q * bdx_q + bdy_q * bdy_q;
    take = !(cd_l >= cd_r) && !(cb_l < cb_r) && !((cb_l == cb_r) && (pd < bd));
  end

  // Scan position and the running extent of the current row.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_col_q  <= '0;
      scan_row_q  <= '0;
      cur_occ_q   <= 1'b0;
      cur_left_q  <= '0;
      cur_right_q <= '0;
    end else if (accept && (req == REQ_FRAME)) begin
      scan_col_q <= '0;
      scan_row_q <= '0;
    end else if (accept && (req == REQ_PIXEL)) begin
      scan_col_q <= col_d;
      scan_row_q <= row_d;
      if (pix_we) begin
        cur_occ_q   <= pix_occ;
        cur_left_q  <= pix_left;
        cur_right_q <= pix_right;
      end
    end
  end

  // Hull walk sequencer and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      phase_q      <= PH_IDLE;
      start_mode_q <= 1'b0;
      j_q          <= '0;
      found_q      <= 1'b0;
      bdx_q        <= '0;
      bdy_q        <= '0;
      bx_q         <= '0;
      by_q         <= '0;
      pivx_q       <= '0;
      pivy_q       <= '0;
      dirx_q       <= DW'(1);
      diry_q       <= '0;
      out_valid_q  <= 1'b0;
      vx_q         <= '0;
      vy_q         <= '0;
      st_q         <= ST_VERTEX;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept && (req == REQ_FRAME)) begin
            pivx_q  <= '0;
            pivy_q  <= '0;
            dirx_q  <= DW'(1);
            diry_q  <= '0;
            phase_q <= PH_IDLE;
          end else if (accept && (req == REQ_VERTEX)) begin
            if (phase_q == PH_DONE) begin
              out_valid_q <= 1'b1;
              vx_q        <= '0;
              vy_q        <= '0;
              st_q        <= ST_DONE;
            end else begin
              start_mode_q <= (phase_q == PH_IDLE);
              j_q          <= '0;
              found_q      <= 1'b0;
              bdx_q        <= -dirx_q;
              bdy_q        <= -diry_q;
              state_q      <= S_SCAN;
            end
          end
        end
        // The row word is read here and arrives in the next state.
        S_SCAN: begin
          if (j_q >= h_c) begin
            state_q <= S_FIN;
          end else begin
            state_q <= S_LEFT;
          end
        end
        S_LEFT: begin
          if (!row_hit) begin
            j_q     <= j_q + 1'b1;
            state_q <= S_SCAN;
          end else if (start_mode_q) begin
            found_q <= 1'b1;
            bx_q    <= rd_right;
            by_q    <= j_q[RW-1:0];
            state_q <= S_FIN;
          end else begin
            if (take) begin
              found_q <= 1'b1;
              bdx_q   <= px;
              bdy_q   <= py;
              bx_q    <= cand_col;
              by_q    <= j_q[RW-1:0];
            end
            state_q <= S_RIGHT;
          end
        end
        S_RIGHT: begin
          if (take) begin
            found_q <= 1'b1;
            bdx_q   <= px;
            bdy_q   <= py;
            bx_q    <= cand_col;
            by_q    <= j_q[RW-1:0];
          end
          j_q     <= j_q + 1'b1;
          state_q <= S_SCAN;
        end
        S_FIN: begin
          out_valid_q <= 1'b1;
          state_q     <= S_IDLE;
          if (!found_q) begin
            phase_q <= PH_DONE;
            vx_q    <= '0;
            vy_q    <= '0;
            st_q    <= start_mode_q ? ST_EMPTY : ST_NOFULCRUM;
          end else begin
            pivx_q <= bx_q;
            pivy_q <= by_q;
            vx_q   <= COORD_W'(bx_q);
            vy_q   <= COORD_W'(by_q);
            if (start_mode_q) begin
              dirx_q  <= DW'(1);
              diry_q  <= '0;
              phase_q <= PH_WALK;
              st_q    <= ST_VERTEX;
            end else if ((diry_q < 0) && (bdy_q >= 0)) begin
              phase_q <= PH_DONE;
              st_q    <= ST_CLOSE;
            end else begin
              dirx_q <= bdx_q;
              diry_q <= bdy_q;
              st_q   <= ST_VERTEX;
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign vertex_x_o    = vx_q;
  assign vertex_y_o    = vy_q;
  assign hull_status_o = st_q;

  // The sequencer is always in exactly one state.
  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("walk state is not one-hot");

  // No beat is taken while the memory sweep runs.
  a_busy_no_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !in_ready_o)
    else $error("input taken during hull sweep");

  // A waiting result is not dropped.
  a_out_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> out_valid_q)
    else $error("result lost before it was taken");

  // The right end is only tested on a row that holds set pixels.
  a_right_occupied: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RIGHT) |-> row_hit)
    else $error("candidate test on an empty row");

endmodule

`default_nettype wire

[rtl/mrh_ext_ram.sv]
`default_nettype none

// Row extent store: one word per row holding the left and right set column.
module mrh_ext_ram #(
  parameter int DEPTH = 256,
  parameter int AW    = 8,
  parameter int DW    = 16
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [DW-1:0] wdata_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [DEPTH];

  // Synchronous write and registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire
